### rtl/core/anir_pkg.sv
package anir_pkg;

  localparam int unsigned CFG_W      = 50;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CHAN_W     = 2;
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned SHIFT_W    = 4;

  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_DIGITAL  = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  localparam logic [3:0] SCALE_BASE = 4'd6;
  localparam logic [7:0] FACTOR_MASK = 8'hff;

  localparam logic REPORT_VOLTAGE = 1'b0;
  localparam logic REPORT_PIN     = 1'b1;

  // register layout, MSB first: scale, factor, mode, period, high, low
  typedef struct packed {
    logic [3:0]  scale;
    logic [7:0]  factor;
    logic [1:0]  mode;
    logic [15:0] period;
    logic [9:0]  high;
    logic [9:0]  low;
  } setup_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   chan_sel;
    logic [SAMPLE_W-1:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_chan;
    logic              report_kind;
    logic [VOLT_W-1:0] voltage;
    logic              pin_high;
  } out_beat_t;

endpackage

### rtl/core/anir_cfg_regs.sv
module anir_cfg_regs #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [anir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [anir_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [anir_pkg::CHAN_W-1:0]    rd_chan,
  output anir_pkg::setup_t               rd_setup
);

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  anir_pkg::setup_t setup_r   [NUM_CHANNELS];
  anir_pkg::setup_t setup_nxt [NUM_CHANNELS];

  logic wr_hit;

  assign wr_hit = cfg_we &&
                  ({1'b0, cfg_index} < (anir_pkg::CFG_IDX_W + 1)'(NUM_CHANNELS));

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      setup_nxt[i] = setup_r[i];
    end
    if (wr_hit) begin
      setup_nxt[cfg_index[CH_W-1:0]] = anir_pkg::setup_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!rst_n) begin
        setup_r[i] <= '0;
      end else begin
        setup_r[i] <= setup_nxt[i];
      end
    end
  end

  // caller guarantees rd_chan is in range when the result is used
  assign rd_setup = setup_r[rd_chan[CH_W-1:0]];

endmodule

### rtl/core/anir_chan_proc.sv
module anir_chan_proc #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned POLL_STEP    = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  anir_pkg::in_beat_t   beat,
  input  anir_pkg::setup_t     setup,
  output logic                 has_result,
  output anir_pkg::out_beat_t  result
);

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic                          level_r     [NUM_CHANNELS];
  logic                          level_nxt   [NUM_CHANNELS];
  logic [anir_pkg::COUNT_W-1:0]  count_r     [NUM_CHANNELS];
  logic [anir_pkg::COUNT_W-1:0]  count_nxt   [NUM_CHANNELS];

  logic [CH_W-1:0]               idx;
  logic                          in_range;
  logic                          cur_level;
  logic [anir_pkg::COUNT_W-1:0]  cnt_inc;
  logic                          period_hit;
  logic [17:0]                   prod_full;
  logic [anir_pkg::VOLT_W-1:0]   prod;
  logic [anir_pkg::SHIFT_W-1:0]  shamt;
  logic                          go_high;
  logic                          go_low;
  logic                          is_periodic;
  logic                          is_digital;

  assign idx       = beat.chan_sel[CH_W-1:0];
  assign in_range  = ({1'b0, beat.chan_sel} < (anir_pkg::CHAN_W + 1)'(NUM_CHANNELS));
  assign cur_level = level_r[idx];

  assign is_periodic = in_range && (setup.mode == anir_pkg::MODE_PERIODIC);
  assign is_digital  = in_range && (setup.mode == anir_pkg::MODE_DIGITAL);

  assign cnt_inc    = count_r[idx] + anir_pkg::COUNT_W'(POLL_STEP);
  assign period_hit = (cnt_inc >= {1'b0, setup.period});

  assign prod_full = 18'(beat.sample) * 18'(setup.factor & anir_pkg::FACTOR_MASK);
  assign prod      = prod_full[anir_pkg::VOLT_W-1:0];
  assign shamt     = (setup.scale < anir_pkg::SCALE_BASE) ? '0
                                                           : setup.scale - anir_pkg::SCALE_BASE;

  assign go_high = !cur_level && (beat.sample > setup.high);
  assign go_low  = cur_level && (beat.sample < setup.low);

  always_comb begin
    has_result         = 1'b0;
    result.out_chan    = beat.chan_sel;
    result.report_kind = anir_pkg::REPORT_VOLTAGE;
    result.voltage     = '0;
    result.pin_high    = 1'b0;
    if (is_periodic && period_hit) begin
      has_result     = 1'b1;
      result.voltage = prod >> shamt;
    end else if (is_digital && (go_high || go_low)) begin
      has_result         = 1'b1;
      result.report_kind = anir_pkg::REPORT_PIN;
      result.pin_high    = go_high;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      level_nxt[i] = level_r[i];
      count_nxt[i] = count_r[i];
    end
    if (fire && is_periodic) begin
      count_nxt[idx] = period_hit ? '0 : cnt_inc;
    end
    if (fire && is_digital && (go_high || go_low)) begin
      level_nxt[idx] = go_high;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!rst_n) begin
        level_r[i] <= 1'b0;
        count_r[i] <= '0;
      end else begin
        level_r[i] <= level_nxt[i];
        count_r[i] <= count_nxt[i];
      end
    end
  end

endmodule

### rtl/core/analog_input_reporter_unit.sv
// Analog input reporter: takes one ADC sample per beat and issues at most one
// report beat. A channel in periodic mode adds POLL_STEP to its counter and
// reports (sample*factor mod 2^16) >> max(scale-6,0) once the counter reaches
// its period; a channel in digital mode reports its pin level when the
// hysteresis comparator flips. One sample is taken every cycle unless in_stall
// is high; it waits in the input register, where channel state is read and
// updated, until the output slot is free or draining. Users must write channel
// settings through cfg_* while no sample is in flight; it is not enforced.
module analog_input_reporter_unit #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned POLL_STEP    = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  anir_pkg::in_beat_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output anir_pkg::out_beat_t            out_data,
  input  logic                           cfg_we,
  input  logic [anir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [anir_pkg::CFG_W-1:0]     cfg_wdata
);

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  anir_pkg::in_beat_t   s1_beat_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  anir_pkg::out_beat_t  out_beat_r;

  anir_pkg::setup_t     setup;
  logic                 adv;
  logic                 fire;
  logic                 has_result;
  anir_pkg::out_beat_t  result;

  // output slot is free or is being drained this cycle
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  anir_cfg_regs #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rd_chan   (s1_beat_r.chan_sel),
    .rd_setup  (setup)
  );

  anir_chan_proc #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .POLL_STEP    (POLL_STEP)
  ) u_proc (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .beat       (s1_beat_r),
    .setup      (setup),
    .has_result (has_result),
    .result     (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_valid_r && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_beat_r <= in_data;
    end
    if (fire && has_result) begin
      out_beat_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

endmodule

### dv/analog_input_reporter_unit_tb.sv
module analog_input_reporter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_CH      = 4;
  localparam int unsigned POLL_STEP   = 10;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_WAIT  = 4;
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  anir_pkg::in_beat_t             in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  anir_pkg::out_beat_t            out_data;
  logic                           cfg_we = 1'b0;
  logic [anir_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [anir_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // channel model: settings, comparator levels, period counters
  anir_pkg::setup_t              chan_setup [NUM_CH];
  logic                          chan_level [NUM_CH];
  logic [anir_pkg::COUNT_W-1:0]  chan_count [NUM_CH];

  anir_pkg::in_beat_t  sample_q [$];
  anir_pkg::out_beat_t report_q [$];

  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  int unsigned in_gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_req_n = 0;
  int unsigned hold_seen = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned samples_taken = 0;
  int unsigned volt_seen = 0;
  int unsigned pin_seen = 0;
  int unsigned setups_written = 0;

  analog_input_reporter_unit #(
    .NUM_CHANNELS (NUM_CH),
    .POLL_STEP    (POLL_STEP)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // updates channel state for one accepted sample; returns 1 if it reports
  function automatic bit predict_report(input anir_pkg::in_beat_t b,
                                        output anir_pkg::out_beat_t rep);
    anir_pkg::setup_t             s;
    logic [anir_pkg::COUNT_W-1:0] nxt;
    logic [17:0]                  full;
    int unsigned                  sh;
    s = chan_setup[b.chan_sel];
    rep = '0;
    rep.out_chan = b.chan_sel;
    if (s.mode == anir_pkg::MODE_PERIODIC) begin
      nxt = chan_count[b.chan_sel] + anir_pkg::COUNT_W'(POLL_STEP);
      if (nxt < {1'b0, s.period}) begin
        chan_count[b.chan_sel] = nxt;
        return 1'b0;
      end
      chan_count[b.chan_sel] = '0;
      full = 18'(b.sample) * 18'(s.factor);
      sh = (s.scale < anir_pkg::SCALE_BASE) ? 0 : 32'(s.scale - anir_pkg::SCALE_BASE);
      rep.report_kind = anir_pkg::REPORT_VOLTAGE;
      rep.voltage = full[15:0] >> sh;
      return 1'b1;
    end
    if (s.mode == anir_pkg::MODE_DIGITAL) begin
      if (!chan_level[b.chan_sel] && b.sample > s.high) begin
        chan_level[b.chan_sel] = 1'b1;
      end else if (chan_level[b.chan_sel] && b.sample < s.low) begin
        chan_level[b.chan_sel] = 1'b0;
      end else begin
        return 1'b0;
      end
      rep.report_kind = anir_pkg::REPORT_PIN;
      rep.pin_high = chan_level[b.chan_sel];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic anir_pkg::setup_t mk_setup(input logic [1:0] mode,
                                                input int unsigned period,
                                                input int unsigned low,
                                                input int unsigned high,
                                                input int unsigned factor,
                                                input int unsigned scale);
    anir_pkg::setup_t s;
    s.mode = mode;
    s.period = 16'(period);
    s.low = 10'(low);
    s.high = 10'(high);
    s.factor = 8'(factor);
    s.scale = 4'(scale);
    return s;
  endfunction

  function automatic anir_pkg::setup_t rand_setup();
    anir_pkg::setup_t s;
    logic [9:0]       t;
    int unsigned      pick;
    s = '0;
    pick = $urandom_range(0, 7);
    case (pick)
      0: s.mode = anir_pkg::MODE_OFF;
      1: s.mode = anir_pkg::MODE_UNUSED;
      2, 3, 4: s.mode = anir_pkg::MODE_PERIODIC;
      default: s.mode = anir_pkg::MODE_DIGITAL;
    endcase
    s.period = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 80));
    s.low = 10'($urandom_range(0, 1023));
    s.high = 10'($urandom_range(0, 1023));
    // mostly a proper hysteresis band, sometimes inverted
    if (s.low > s.high && $urandom_range(0, 3) != 0) begin
      t = s.low;
      s.low = s.high;
      s.high = t;
    end
    s.factor = 8'($urandom_range(0, 255));
    s.scale = 4'($urandom_range(0, 15));
    return s;
  endfunction

  // samples cluster around the thresholds so the comparator keeps flipping
  function automatic anir_pkg::in_beat_t rand_sample();
    anir_pkg::in_beat_t b;
    anir_pkg::setup_t   s;
    b.chan_sel = anir_pkg::CHAN_W'($urandom_range(0, NUM_CH - 1));
    s = chan_setup[b.chan_sel];
    case ($urandom_range(0, 9))
      0: b.sample = '0;
      1: b.sample = '1;
      2, 3: b.sample = anir_pkg::SAMPLE_W'(s.high + $urandom_range(0, 2) - 1);
      4, 5: b.sample = anir_pkg::SAMPLE_W'(s.low + $urandom_range(0, 2) - 1);
      default: b.sample = anir_pkg::SAMPLE_W'($urandom_range(0, 1023));
    endcase
    return b;
  endfunction

  task automatic push_sample(input int unsigned ch, input int unsigned smp);
    anir_pkg::in_beat_t b;
    b.chan_sel = anir_pkg::CHAN_W'(ch);
    b.sample = anir_pkg::SAMPLE_W'(smp);
    sample_q.push_back(b);
  endtask

  task automatic write_setup(input int unsigned idx, input anir_pkg::setup_t s);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= anir_pkg::CFG_IDX_W'(idx);
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    chan_setup[anir_pkg::CFG_IDX_W'(idx)] = s;
    setups_written++;
  endtask

  // a sample that reports nothing may still sit in the pipe after the last beat
  task automatic wait_drained();
    do @(negedge clk); while (sample_q.size() != 0 || in_valid || report_q.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic flag_field(input string name, input int unsigned want_v,
                            input int unsigned got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    fail_cnt++;
  endtask

  // sender
  always @(posedge clk) begin : drive_in
    anir_pkg::out_beat_t rep;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        samples_taken++;
        if (predict_report(in_data, rep)) report_q.push_back(rep);
      end
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        in_data <= sample_q.pop_front();
        in_valid <= 1'b1;
        in_gap_left = in_idle_on ? $urandom_range(0, 9) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : take_out
    anir_pkg::out_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $display("%0t: report with none pending, got chan %0d kind %0d volt %0d pin %0d",
                   $time, out_data.out_chan, out_data.report_kind, out_data.voltage,
                   out_data.pin_high);
          fail_cnt++;
        end else begin
          want = report_q.pop_front();
          if (out_data.out_chan !== want.out_chan)
            flag_field("out_chan", 32'(want.out_chan), 32'(out_data.out_chan));
          if (out_data.report_kind !== want.report_kind)
            flag_field("report_kind", 32'(want.report_kind), 32'(out_data.report_kind));
          if (out_data.voltage !== want.voltage)
            flag_field("voltage", 32'(want.voltage), 32'(out_data.voltage));
          if (out_data.pin_high !== want.pin_high)
            flag_field("pin_high", 32'(want.pin_high), 32'(out_data.pin_high));
        end
        if (out_data.report_kind == anir_pkg::REPORT_VOLTAGE) volt_seen++;
        else pin_seen++;
        stall_left = out_idle_on ? $urandom_range(0, 9) : 0;
      end
      if (hold_req_n != hold_seen) begin
        hold_seen = hold_req_n;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d reports still pending", $time, report_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_CH; i++) begin
      chan_setup[i] = '0;
      chan_level[i] = 1'b0;
      chan_count[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: every channel off
    push_sample(0, 1023);
    push_sample(3, 0);
    wait_drained();

    write_setup(0, mk_setup(anir_pkg::MODE_PERIODIC, 0, 0, 0, 255, 0));
    write_setup(1, mk_setup(anir_pkg::MODE_PERIODIC, 25, 0, 0, 128, 15));
    write_setup(2, mk_setup(anir_pkg::MODE_DIGITAL, 0, 100, 900, 0, 0));
    write_setup(3, '1);  // unused mode code with every other field at max
    @(negedge clk);
    push_sample(0, 0);
    push_sample(0, 1023);  // product wraps past 16 bits
    push_sample(0, 1);
    push_sample(1, 1023);
    push_sample(1, 1023);
    push_sample(1, 1023);
    push_sample(2, 500);
    push_sample(2, 900);
    push_sample(2, 901);
    push_sample(2, 1023);
    push_sample(2, 100);
    push_sample(2, 99);
    push_sample(2, 0);
    push_sample(2, 1023);
    push_sample(3, 1023);
    push_sample(3, 0);
    wait_drained();

    // scale at and just above the base, longest period, plain off mode,
    // and channel 2 leaving digital mode while its level is high
    write_setup(0, mk_setup(anir_pkg::MODE_PERIODIC, 65535, 1023, 1023, 1, 6));
    write_setup(1, mk_setup(anir_pkg::MODE_PERIODIC, 10, 0, 0, 255, 7));
    write_setup(2, mk_setup(anir_pkg::MODE_PERIODIC, 15, 0, 1023, 3, 5));
    write_setup(3, mk_setup(anir_pkg::MODE_OFF, 0, 0, 0, 255, 15));
    @(negedge clk);
    push_sample(0, 1023);
    push_sample(1, 1023);
    push_sample(1, 512);
    push_sample(2, 1023);
    push_sample(2, 1023);
    push_sample(3, 1023);
    wait_drained();

    // back to digital: held level is high, so the first high sample does not report
    write_setup(2, mk_setup(anir_pkg::MODE_DIGITAL, 0, 1, 1022, 0, 0));
    @(negedge clk);
    push_sample(2, 1023);
    push_sample(2, 0);
    push_sample(2, 1023);
    wait_drained();

    // back pressure: every sample reports while the receiver holds off
    for (int i = 0; i < NUM_CH; i++)
      write_setup(i, mk_setup(anir_pkg::MODE_PERIODIC, 0, 0, 0, $urandom_range(0, 255),
                              $urandom_range(0, 15)));
    @(negedge clk);
    in_idle_on <= 1'b0;
    out_idle_on <= 1'b0;
    hold_req_n <= hold_req_n + 1;
    for (int i = 0; i < 60; i++) sample_q.push_back(rand_sample());
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < NUM_CH; i++) write_setup(i, rand_setup());
      @(negedge clk);
      in_idle_on <= ($urandom_range(0, 3) != 0);
      out_idle_on <= ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 100; i++) sample_q.push_back(rand_sample());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Run took %0d samples over %0d register writes and checked %0d voltage",
             samples_taken, setups_written, volt_seen);
    $display("reports and %0d pin changes, with one long output hold.", pin_seen);
    if (fail_cnt == 0 && report_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
